// File: sv/pis_pkg.sv
// shared types and constants of the periodic id scheduler
package pis_pkg;

   localparam int DUE_W    = 40;
   localparam int ID_W     = 16;
   localparam int PERIOD_W = 16;

   localparam logic [DUE_W-1:0] DUE_MAX = {DUE_W{1'b1}};

   // request action codes
   localparam logic [1:0] ACT_REGISTER = 2'd0;
   localparam logic [1:0] ACT_NEXT     = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;
   localparam logic [1:0] ACT_UNUSED   = 2'd3;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // command broadcast to every cell of the sorted chain
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2,
      OP_CLEAR  = 2'd3
   } cell_op_type;

   // payload held by one cell
   typedef struct packed {
      logic [DUE_W-1:0]    due;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] step;
   } slot_data_type;

endpackage

// File: sv/pis_if.sv
// request and response channel interfaces of the periodic id scheduler
interface pis_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] entry_id;
   logic [15:0] entry_period;

   modport source (output valid, output action, output entry_id, output entry_period,
                   input ready);
   modport sink   (input valid, input action, input entry_id, input entry_period,
                   output ready);
endinterface

interface pis_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] chosen_id;
   logic [1:0]  status;

   modport source (output valid, output chosen_id, output status, input ready);
   modport sink   (input valid, input chosen_id, input status, output ready);
endinterface

// File: sv/pis_cell.sv
// one cell of the sorted entry chain
module pis_cell #(
   parameter int TAG_W = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pis_pkg::cell_op_type   op,
   input  pis_pkg::slot_data_type ins_data,
   input  logic [TAG_W-1:0]       ins_tag,
   input  logic                   left_valid,
   input  pis_pkg::slot_data_type left_data,
   input  logic [TAG_W-1:0]       left_tag,
   input  logic                   left_lt,
   input  logic                   right_valid,
   input  pis_pkg::slot_data_type right_data,
   input  logic [TAG_W-1:0]       right_tag,
   output logic                   cur_valid,
   output pis_pkg::slot_data_type cur_data,
   output logic [TAG_W-1:0]       cur_tag,
   output logic                   cur_lt
);

   logic                   valid_ff, valid_in;
   pis_pkg::slot_data_type data_ff, data_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;

   // this cell sorts ahead of the key being inserted
   assign cur_lt = valid_ff &&
                   ({data_ff.due, data_ff.id, tag_ff} < {ins_data.due, ins_data.id, ins_tag});

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      tag_in   = tag_ff;
      case (op)
         pis_pkg::OP_INSERT: begin
            if (!cur_lt) begin
               if (left_lt) begin
                  valid_in = 1'b1;
                  data_in  = ins_data;
                  tag_in   = ins_tag;
               end else begin
                  valid_in = left_valid;
                  data_in  = left_data;
                  tag_in   = left_tag;
               end
            end
         end
         pis_pkg::OP_SHIFT: begin
            valid_in = right_valid;
            data_in  = right_data;
            tag_in   = right_tag;
         end
         pis_pkg::OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      tag_ff  <= tag_in;
   end

   assign cur_valid = valid_ff;
   assign cur_data  = data_ff;
   assign cur_tag   = tag_ff;

endmodule

// File: sv/periodic_id_scheduler.sv
// top level of the periodic id scheduler: sorted cell chain and control
// response: the beat is registered at the accept edge and appears on rsp in the next cycle
// register, clear and unused beats complete at accept; a next beat first pops the head cell and
//   then, in the reinsert state, inserts the advanced entry back into the chain, taking no new beat meanwhile
// a full or empty case answers like any other beat and leaves the chain alone
// reset: synchronous, clears all cell valid flags, the entry count and the response valid flag
module periodic_id_scheduler #(
   parameter int CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   pis_req_if.sink    req,
   pis_rsp_if.source  rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int TAG_W = $clog2(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE     = 2'b01,
      ST_REINSERT = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // entry count, also the insertion tag that breaks full ties by slot order
   logic [CNT_W-1:0] count_ff, count_in;

   // advanced head entry waiting to go back into the chain
   pis_pkg::slot_data_type reins_data_ff, reins_data_in;
   logic [TAG_W-1:0]       reins_tag_ff, reins_tag_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_chosen_id_ff, rsp_chosen_id_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // chain broadcast
   pis_pkg::cell_op_type   cell_op;
   pis_pkg::slot_data_type ins_data;
   logic [TAG_W-1:0]       ins_tag;

   // chain taps
   logic                   cell_valid [CAPACITY];
   logic [CAPACITY-1:0]    cell_valid_vec;
   pis_pkg::slot_data_type cell_data  [CAPACITY];
   logic [TAG_W-1:0]       cell_tag   [CAPACITY];
   logic                   cell_lt    [CAPACITY];

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   logic [pis_pkg::DUE_W:0] due_sum;

   // a new beat is taken only between operations and when the response slot frees up
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // head due time plus its period, with a carry bit so the result can be clamped at the top of the due range
   assign due_sum = {1'b0, cell_data[0].due} +
                    (pis_pkg::DUE_W + 1)'(cell_data[0].step);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      reins_data_in    = reins_data_ff;
      reins_tag_in     = reins_tag_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp.ready;
      rsp_chosen_id_in = rsp_chosen_id_ff;
      rsp_status_in    = rsp_status_ff;
      cell_op          = pis_pkg::OP_HOLD;
      // fresh entry: first due time is its period, tag is its slot number
      ins_data.due     = pis_pkg::DUE_W'(req.entry_period);
      ins_data.id      = req.entry_id;
      ins_data.step    = req.entry_period;
      ins_tag          = count_ff[TAG_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in     = 1'b1;
               rsp_chosen_id_in = '0;
               rsp_status_in    = pis_pkg::STATUS_OK;
               case (req.action)
                  pis_pkg::ACT_REGISTER: begin
                     if (is_full) begin
                        rsp_status_in = pis_pkg::STATUS_FULL;
                     end else begin
                        cell_op  = pis_pkg::OP_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pis_pkg::ACT_NEXT: begin
                     if (is_empty) begin
                        rsp_status_in = pis_pkg::STATUS_EMPTY;
                     end else begin
                        // head cell is the minimum; pop it and hold its advanced copy
                        rsp_chosen_id_in   = cell_data[0].id;
                        cell_op            = pis_pkg::OP_SHIFT;
                        reins_data_in      = cell_data[0];
                        reins_data_in.due  = due_sum[pis_pkg::DUE_W] ? pis_pkg::DUE_MAX
                                                                     : due_sum[pis_pkg::DUE_W-1:0];
                        reins_tag_in       = cell_tag[0];
                        state_in           = ST_REINSERT;
                     end
                  end
                  pis_pkg::ACT_CLEAR: begin
                     cell_op  = pis_pkg::OP_CLEAR;
                     count_in = '0;
                  end
                  default: begin
                     rsp_status_in = pis_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ST_REINSERT: begin
            cell_op  = pis_pkg::OP_INSERT;
            ins_data = reins_data_ff;
            ins_tag  = reins_tag_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reins_data_ff    <= reins_data_in;
      reins_tag_ff     <= reins_tag_in;
      rsp_chosen_id_ff <= rsp_chosen_id_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.chosen_id = rsp_chosen_id_ff;
   assign rsp.status    = rsp_status_ff;

   // sorted chain, cell 0 holds the earliest due entry, empty cells sit at the tail
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                   left_valid;
      pis_pkg::slot_data_type left_data;
      logic [TAG_W-1:0]       left_tag;
      logic                   left_lt;
      logic                   right_valid;
      pis_pkg::slot_data_type right_data;
      logic [TAG_W-1:0]       right_tag;

      if (i == 0) begin : g_head
         // the head takes a new key whenever it does not sort ahead of it
         assign left_valid = 1'b0;
         assign left_data  = '0;
         assign left_tag   = '0;
         assign left_lt    = 1'b1;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_data  = cell_data[i-1];
         assign left_tag   = cell_tag[i-1];
         assign left_lt    = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_data  = '0;
         assign right_tag   = '0;
      end else begin : g_next
         assign right_valid = cell_valid[i+1];
         assign right_data  = cell_data[i+1];
         assign right_tag   = cell_tag[i+1];
      end

      pis_cell #(
         .TAG_W (TAG_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .ins_data    (ins_data),
         .ins_tag     (ins_tag),
         .left_valid  (left_valid),
         .left_data   (left_data),
         .left_tag    (left_tag),
         .left_lt     (left_lt),
         .right_valid (right_valid),
         .right_data  (right_data),
         .right_tag   (right_tag),
         .cur_valid   (cell_valid[i]),
         .cur_data    (cell_data[i]),
         .cur_tag     (cell_tag[i]),
         .cur_lt      (cell_lt[i])
      );

      assign cell_valid_vec[i] = cell_valid[i];
   end

   // entry count never passes the chain length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // between operations the occupied cells match the entry count
   a_count_cells: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(cell_valid_vec) == int'(count_ff))
      else $error("occupied cells differ from entry count");

   // a next beat on a non-empty chain always goes through the reinsert cycle
   a_next_reinsert: assert property (@(posedge clock) disable iff (reset)
      accept && req.action == pis_pkg::ACT_NEXT && !is_empty |=> state_ff == ST_REINSERT)
      else $error("next beat skipped reinsert");

   // reinsert always returns to idle in the next cycle
   a_reinsert_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REINSERT |=> state_ff == ST_IDLE)
      else $error("reinsert did not return to idle");

   // no beat is taken while the popped entry waits to go back
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REINSERT |-> !req.ready)
      else $error("ready raised during reinsert");

endmodule
